FILE: rtl/basic_token_scanner_unit_assert.svh
// assertion macros used by the token scanner rtl
`ifndef BASIC_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define BASIC_TOKEN_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bts_pkg.sv
// types, codes and decode functions for the basic token scanner
`timescale 1ns / 1ps
`default_nettype none
package bts_pkg;

  localparam int POSITION_BITS_DEF = 32;
  localparam int LINE_BITS_DEF     = 32;
  localparam int OUT_QUEUE_DEPTH   = 4;
  localparam int KEYWORD_COUNT     = 11;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } bts_in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] line_number;
    logic [31:0] lexeme_start;
    logic [31:0] lexeme_length;
    logic        last_of_run;
  } bts_out_t;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_NUMBER = 4'b0010,
    MODE_WORD   = 4'b0100,
    MODE_STRING = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } op_dec_t;

  localparam logic [4:0] KIND_NEWLINE = 5'd0;
  localparam logic [4:0] KIND_STRING  = 5'd1;
  localparam logic [4:0] KIND_NUMBER  = 5'd2;
  localparam logic [4:0] KIND_IDENT   = 5'd3;
  localparam logic [4:0] KIND_LET     = 5'd4;
  localparam logic [4:0] KIND_PLUS    = 5'd15;
  localparam logic [4:0] KIND_MINUS   = 5'd16;
  localparam logic [4:0] KIND_STAR    = 5'd17;
  localparam logic [4:0] KIND_SLASH   = 5'd18;
  localparam logic [4:0] KIND_EQUAL   = 5'd19;
  localparam logic [4:0] KIND_LPAREN  = 5'd20;
  localparam logic [4:0] KIND_RPAREN  = 5'd21;
  localparam logic [4:0] KIND_COMMA   = 5'd22;
  localparam logic [4:0] KIND_EOF     = 5'd23;

  localparam logic [7:0] CHR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHR_QUOTE   = 8'h22;
  localparam logic [7:0] CHR_LPAREN  = 8'h28;
  localparam logic [7:0] CHR_RPAREN  = 8'h29;
  localparam logic [7:0] CHR_STAR    = 8'h2A;
  localparam logic [7:0] CHR_PLUS    = 8'h2B;
  localparam logic [7:0] CHR_COMMA   = 8'h2C;
  localparam logic [7:0] CHR_MINUS   = 8'h2D;
  localparam logic [7:0] CHR_SLASH   = 8'h2F;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;
  localparam logic [7:0] CHR_EQUAL   = 8'h3D;
  localparam logic [7:0] CHR_UP_A    = 8'h41;
  localparam logic [7:0] CHR_UP_Z    = 8'h5A;
  localparam logic [7:0] CHR_UNDER   = 8'h5F;
  localparam logic [7:0] CHR_LO_A    = 8'h61;
  localparam logic [7:0] CHR_LO_Z    = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // upper-case keyword spellings, first byte highest
  localparam logic [47:0] KEYWORD_CODE [KEYWORD_COUNT] = '{
    48'h4C4554,       48'h5052494E54, 48'h494E505554, 48'h4946,
    48'h5448454E,     48'h474F544F,   48'h464F52,     48'h544F,
    48'h4E455854,     48'h474F535542, 48'h52455455524E
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHR_ZERO) && (c <= CHR_NINE);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= CHR_LO_A) && (c <= CHR_LO_Z);
  endfunction

  function automatic logic starts_word(input logic [7:0] c);
    return is_lower(c) || ((c >= CHR_UP_A) && (c <= CHR_UP_Z)) || (c == CHR_UNDER);
  endfunction

  function automatic logic continues_word(input logic [7:0] c);
    return starts_word(c) || is_digit(c);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return is_lower(c) ? (c - CASE_OFFSET) : c;
  endfunction

  function automatic op_dec_t op_decode(input logic [7:0] c);
    op_dec_t d;
    d.hit = 1'b1;
    unique case (c)
      CHR_PLUS:   d.kind = KIND_PLUS;
      CHR_MINUS:  d.kind = KIND_MINUS;
      CHR_STAR:   d.kind = KIND_STAR;
      CHR_SLASH:  d.kind = KIND_SLASH;
      CHR_EQUAL:  d.kind = KIND_EQUAL;
      CHR_LPAREN: d.kind = KIND_LPAREN;
      CHR_RPAREN: d.kind = KIND_RPAREN;
      CHR_COMMA:  d.kind = KIND_COMMA;
      default: begin
        d.hit  = 1'b0;
        d.kind = KIND_NEWLINE;
      end
    endcase
    return d;
  endfunction

  function automatic logic [4:0] word_kind(input logic [47:0] word, input logic too_long);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      if (!too_long && (word == KEYWORD_CODE[k])) begin
        kind = KIND_LET + 5'(k);
      end
    end
    return kind;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/basic_token_scanner_unit.sv
// streaming lexer for a small basic dialect with a token output queue
// an item's tokens are written into the registered queue when it transfers; out_valid follows the queue count
// throughput: one byte per cycle while out_ready stays high and items give at most one token each
// items giving two tokens fill a four-entry queue; in_ready drops below two free slots
// reset: synchronous active-low rst_n clears scan state, counters and queue at once
`timescale 1ns / 1ps
`default_nettype none
module basic_token_scanner_unit #(
  parameter int POSITION_BITS = bts_pkg::POSITION_BITS_DEF,
  parameter int LINE_BITS     = bts_pkg::LINE_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire bts_pkg::bts_in_t  in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output bts_pkg::bts_out_t      out_data
);
  import bts_pkg::*;

  localparam int DEPTH = OUT_QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  scan_mode_t               mode_r, mode_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [47:0]              word_r, word_nxt;
  logic                     long_r, long_nxt;

  bts_out_t                 queue_r [DEPTH];
  logic [PTR_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;

  logic                     in_fire, out_fire;
  logic [1:0]               push_n;
  bts_out_t                 res0, res1, flush_tok, idle_tok, eof_tok;
  logic [POSITION_BITS-1:0] len_w;
  logic                     do_flush, do_idle;
  logic [7:0]               c;
  op_dec_t                  op;

  function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
    return (v == {POSITION_BITS{1'b1}}) ? v : v + POSITION_BITS'(1);
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] v);
    return (v == {LINE_BITS{1'b1}}) ? v : v + LINE_BITS'(1);
  endfunction

  assign in_ready  = rst_n && (cnt_r <= CNT_W'(DEPTH - 2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = queue_r[rd_ptr_r];
  assign c         = in_data.source_byte;
  assign op        = op_decode(c);
  assign len_w     = pos_r - start_r;

  always_comb begin
    flush_tok.line_number   = 32'(line_r);
    flush_tok.lexeme_start  = 32'(start_r);
    flush_tok.lexeme_length = 32'(len_w);
    flush_tok.last_of_run   = 1'b0;
    unique case (mode_r)
      MODE_NUMBER: flush_tok.token_kind = KIND_NUMBER;
      MODE_WORD:   flush_tok.token_kind = word_kind(word_r, long_r);
      MODE_STRING: flush_tok.token_kind = KIND_STRING;
      default:     flush_tok.token_kind = KIND_IDENT;
    endcase

    idle_tok.token_kind    = (c == CHR_NEWLINE) ? KIND_NEWLINE : op.kind;
    idle_tok.line_number   = 32'(line_r);
    idle_tok.lexeme_start  = 32'(pos_r);
    idle_tok.lexeme_length = 32'd1;
    idle_tok.last_of_run   = 1'b1;

    eof_tok.token_kind    = KIND_EOF;
    eof_tok.line_number   = 32'(line_r);
    eof_tok.lexeme_start  = 32'(pos_r);
    eof_tok.lexeme_length = 32'd0;
    eof_tok.last_of_run   = 1'b1;
  end

  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    word_nxt  = word_r;
    long_nxt  = long_r;
    res0      = flush_tok;
    res1      = idle_tok;
    push_n    = 2'd0;
    do_flush  = 1'b0;
    do_idle   = 1'b0;
    if (in_fire) begin
      if (in_data.end_of_source) begin
        // flush any open token, then eof; state back to reset values
        if (mode_r != MODE_IDLE) begin
          res1   = eof_tok;
          push_n = 2'd2;
        end else begin
          res0   = eof_tok;
          push_n = 2'd1;
        end
        mode_nxt  = MODE_IDLE;
        line_nxt  = LINE_BITS'(1);
        pos_nxt   = '0;
        start_nxt = '0;
        word_nxt  = '0;
        long_nxt  = 1'b0;
      end else begin
        pos_nxt = pos_inc(pos_r);
        priority if (mode_r == MODE_STRING) begin
          if (c == CHR_QUOTE) begin
            do_flush = 1'b1;
            mode_nxt = MODE_IDLE;
          end else if (c == CHR_NEWLINE) begin
            line_nxt = line_inc(line_r);
          end
        end else if ((mode_r == MODE_NUMBER) && is_digit(c)) begin
          mode_nxt = MODE_NUMBER;
        end else if ((mode_r == MODE_WORD) && continues_word(c)) begin
          if (word_r[47:40] != 8'd0) begin
            long_nxt = 1'b1;
          end else begin
            word_nxt = {word_r[39:0], to_upper(c)};
          end
        end else begin
          do_flush = (mode_r != MODE_IDLE);
          mode_nxt = MODE_IDLE;
          if (c == CHR_NEWLINE) begin
            do_idle  = 1'b1;
            line_nxt = line_inc(line_r);
          end else if (c == CHR_QUOTE) begin
            mode_nxt  = MODE_STRING;
            start_nxt = pos_inc(pos_r);
          end else if (op.hit) begin
            do_idle = 1'b1;
          end else if (is_digit(c)) begin
            mode_nxt  = MODE_NUMBER;
            start_nxt = pos_r;
          end else if (starts_word(c)) begin
            mode_nxt  = MODE_WORD;
            start_nxt = pos_r;
            word_nxt  = {40'd0, to_upper(c)};
            long_nxt  = 1'b0;
          end
        end
        if (do_flush && do_idle) begin
          push_n = 2'd2;
        end else if (do_flush) begin
          res0.last_of_run = 1'b1;
          push_n           = 2'd1;
        end else if (do_idle) begin
          res0   = idle_tok;
          push_n = 2'd1;
        end
      end
    end
  end

  assign cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      line_r   <= LINE_BITS'(1);
      pos_r    <= '0;
      start_r  <= '0;
      word_r   <= '0;
      long_r   <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      word_r   <= word_nxt;
      long_r   <= long_nxt;
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(out_fire);
      cnt_r    <= cnt_nxt;
    end
  end

  // token queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (push_n == 2'd2) begin
      queue_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  `include "basic_token_scanner_unit_assert.svh"

  `BTS_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue overfilled")
  `BTS_ASSERT_NOW(a_push_room, clk, rst_n, push_n != 2'd0, {1'b0, cnt_r} + (CNT_W + 1)'(push_n) <= (CNT_W + 1)'(DEPTH), "push without room")
  `BTS_ASSERT_NOW(a_end_gives_token, clk, rst_n, in_fire && in_data.end_of_source, push_n != 2'd0, "end transfer without eof")
  `BTS_ASSERT_NEXT(a_end_resets, clk, rst_n, in_fire && in_data.end_of_source, (mode_r == MODE_IDLE) && (pos_r == '0) && (line_r == LINE_BITS'(1)), "state not cleared after end")
  `BTS_ASSERT_NOW(a_line_nonzero, clk, rst_n, 1'b1, line_r != '0, "line count reached zero")

endmodule
`default_nettype wire
